// ----- src/bet_pkg.sv -----
package bet_pkg;

    // hold counter width and the width used for count compares
    localparam int CountBits = 16;
    localparam int CfgBits   = 16;
    localparam int CmpW      = (CountBits > CfgBits) ? CountBits : CfgBits;
    localparam int CntW      = $clog2(CmpW);
    localparam int CntMax    = CmpW - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PRESS     = 3'd1,
        EV_RELEASE   = 3'd2,
        EV_LONG      = 3'd3,
        EV_TYPEMATIC = 3'd4
    } event_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_LONG_PRESS  = 2'd0,
        CFG_TYPE_START  = 2'd1,
        CFG_TYPE_REPEAT = 2'd2,
        CFG_ACTIVE_LVL  = 2'd3
    } cfg_idx_t;

endpackage

// ----- src/button_event_typematic.sv -----
// flow: a request passes from the idle state to the finish state, and a held tick that
// needs the typematic repeat test first runs a one-bit-per-cycle remainder unit
// throughput: one request at a time, the next is taken once the result is registered
// reset: asynchronous active low, released phase, counter and event latch cleared,
// registers back to long 100, start 50, repeat 10, active level 0
module button_event_typematic
    import bet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] pin_level, [7:1] zero
    input  logic [0:0]  s_tuser,    // [0] op
    // master result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] is_pressed, [3:1] event_code, [4] notify, [7:5] zero
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [CfgBits-1:0] long_press_reg;
    logic [CfgBits-1:0] type_start_reg;
    logic [CfgBits-1:0] type_repeat_reg;
    logic               active_level_reg;

    // block state
    state_t               state_reg, state_next;
    logic                 phase_pressed_reg, phase_pressed_next;
    logic [CountBits-1:0] hold_count_reg, hold_count_next;
    event_t               latched_event_reg, latched_event_next;
    logic                 last_pressed_reg, last_pressed_next;

    // request held while it is worked on
    op_t  op_reg, op_next;
    logic pressed_reg, pressed_next;

    // remainder unit for the typematic repeat test
    logic [CmpW-1:0]    div_reg, div_next;
    logic [CfgBits-1:0] rem_reg, rem_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [CfgBits:0]   shifted;
    logic [CfgBits+1:0] trial;

    // result register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    logic            accept;
    logic            out_load;
    logic            pressed_now;
    logic [CmpW-1:0] hold_ext, long_ext, start_ext;
    logic            hit_long, hit_start, above_start, repeat_nz;
    logic            need_div;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // compares against the current hold count, stable while a request is in work
    assign pressed_now = (s_tdata[0] == active_level_reg);
    assign hold_ext    = CmpW'(hold_count_reg);
    assign long_ext    = CmpW'(long_press_reg);
    assign start_ext   = CmpW'(type_start_reg);
    assign hit_long    = (hold_ext == long_ext);
    assign hit_start   = (hold_ext == start_ext);
    assign above_start = (hold_ext > start_ext);
    assign repeat_nz   = (type_repeat_reg != '0);

    // only a held tick past the start count with a live repeat needs the remainder
    assign need_div = (op_t'(s_tuser[0]) == OP_TICK) && phase_pressed_reg && pressed_now
                      && !hit_long && !hit_start && above_start && repeat_nz;

    // restoring remainder step: shift one dividend bit in, subtract if it fits
    assign shifted = {rem_reg, div_reg[CmpW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, type_repeat_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_div ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        phase_pressed_next = phase_pressed_reg;
        hold_count_next    = hold_count_reg;
        latched_event_next = latched_event_reg;
        last_pressed_next  = last_pressed_reg;
        op_next            = op_reg;
        pressed_next       = pressed_reg;
        div_next           = div_reg;
        rem_next           = rem_reg;
        cnt_next           = cnt_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op_t'(s_tuser[0]);
                    pressed_next = pressed_now;
                    // dividend is count minus start, only used when count is above start
                    div_next     = hold_ext - start_ext;
                    rem_next     = '0;
                    cnt_next     = CntW'(CntMax);
                end
            end
            ST_DIV:
            begin
                div_next = {div_reg[CmpW-2:0], 1'b0};
                rem_next = trial[CfgBits+1] ? shifted[CfgBits-1:0] : trial[CfgBits-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        last_pressed_next = pressed_reg;
                        if (phase_pressed_reg)
                        begin
                            if (!pressed_reg)
                            begin
                                latched_event_next = EV_RELEASE;
                                phase_pressed_next = 1'b0;
                                hold_count_next    = '0;
                            end
                            else
                            begin
                                if (hit_long)
                                begin
                                    latched_event_next = EV_LONG;
                                end
                                else if (hit_start)
                                begin
                                    latched_event_next = EV_TYPEMATIC;
                                end
                                else if (above_start && repeat_nz && (rem_reg == '0))
                                begin
                                    latched_event_next = EV_TYPEMATIC;
                                end
                                hold_count_next = hold_count_reg + 1'b1;
                            end
                        end
                        else if (pressed_reg)
                        begin
                            latched_event_next = EV_PRESS;
                            phase_pressed_next = 1'b1;
                        end
                        m_tdata_next = {3'b000, (latched_event_next != EV_NONE),
                                        latched_event_next, pressed_reg};
                    end
                    else
                    begin
                        // read returns the latch before clearing, never notifies
                        m_tdata_next = {3'b000, 1'b0, latched_event_reg, last_pressed_reg};
                        latched_event_next = EV_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_pressed_reg <= 1'b0;
            hold_count_reg    <= '0;
            latched_event_reg <= EV_NONE;
            last_pressed_reg  <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            long_press_reg    <= CfgBits'(100);
            type_start_reg    <= CfgBits'(50);
            type_repeat_reg   <= CfgBits'(10);
            active_level_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_pressed_reg <= phase_pressed_next;
            hold_count_reg    <= hold_count_next;
            latched_event_reg <= latched_event_next;
            last_pressed_reg  <= last_pressed_next;
            m_tvalid_reg      <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LONG_PRESS:  long_press_reg   <= cfg_data;
                    CFG_TYPE_START:  type_start_reg   <= cfg_data;
                    CFG_TYPE_REPEAT: type_repeat_reg  <= cfg_data;
                    CFG_ACTIVE_LVL:  active_level_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pressed_reg <= pressed_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // counter only runs in the pressed phase and is cleared on release
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_pressed_reg |-> (hold_count_reg == '0))
        else $error("hold count not clear in released phase");

    // a notify always comes with a latched event
    a_notify_event: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[4]) |-> (m_tdata_reg[3:1] != 3'd0))
        else $error("notify without event");

    // a read result never notifies and leaves the latch empty
    a_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (op_reg == OP_READ)) |=> (!m_tdata_reg[4] && (latched_event_reg == EV_NONE)))
        else $error("read did not clear latch");

    // the remainder unit runs its full bit count before finishing
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg != '0)) |=> (state_reg == ST_DIV))
        else $error("remainder unit left early");

endmodule
